>>> rtl/utf8a_pkg.sv
// shared types, constants and lookup functions of the utf-8 to ascii transliterator
package utf8a_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;
    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] FIRST_PRINTABLE = 21'h000020;
    localparam logic [CP_W-1:0] FIRST_NON_ASCII = 21'h000080;
    localparam logic [CP_W-1:0] HEX4_MAX = 21'h00FFFF;
    localparam logic [CP_W-1:0] HEX5_MAX = 21'h0FFFFF;

    localparam logic [6:0] CHAR_OPEN = 7'h3C;
    localparam logic [6:0] CHAR_CLOSE = 7'h3E;

    // one converted codepoint waiting for expansion
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } job_t;

    typedef enum logic [1:0] {
        KIND_MARK,
        KIND_ASCII,
        KIND_MAP,
        KIND_HEX
    } kind_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] len;
        logic [6:0] c0;
        logic [6:0] c1;
        logic [6:0] c2;
    } map_t;

    function automatic map_t map_ent(input logic [1:0] len, input logic [7:0] a,
                                     input logic [7:0] b, input logic [7:0] c);
        map_t m;
        m.hit = 1'b1;
        m.len = len;
        m.c0 = a[6:0];
        m.c1 = b[6:0];
        m.c2 = c[6:0];
        return m;
    endfunction

    function automatic map_t map_lookup(input logic [CP_W-1:0] cp);
        map_t m;
        m = '0;
        unique case (cp) inside
            [21'h0C0:21'h0C5]:                      m = map_ent(2'd1, "A", 8'h00, 8'h00);
            [21'h0E0:21'h0E5]:                      m = map_ent(2'd1, "a", 8'h00, 8'h00);
            21'h0C6:                                m = map_ent(2'd2, "A", "E", 8'h00);
            21'h0E6:                                m = map_ent(2'd2, "a", "e", 8'h00);
            21'h0C7:                                m = map_ent(2'd1, "C", 8'h00, 8'h00);
            21'h0E7:                                m = map_ent(2'd1, "c", 8'h00, 8'h00);
            [21'h0C8:21'h0CB]:                      m = map_ent(2'd1, "E", 8'h00, 8'h00);
            [21'h0E8:21'h0EB]:                      m = map_ent(2'd1, "e", 8'h00, 8'h00);
            [21'h0CC:21'h0CF]:                      m = map_ent(2'd1, "I", 8'h00, 8'h00);
            [21'h0EC:21'h0EF]:                      m = map_ent(2'd1, "i", 8'h00, 8'h00);
            21'h0D0:                                m = map_ent(2'd1, "D", 8'h00, 8'h00);
            21'h0F0:                                m = map_ent(2'd1, "d", 8'h00, 8'h00);
            21'h0D1:                                m = map_ent(2'd1, "N", 8'h00, 8'h00);
            21'h0F1:                                m = map_ent(2'd1, "n", 8'h00, 8'h00);
            [21'h0D2:21'h0D6], 21'h0D8:             m = map_ent(2'd1, "O", 8'h00, 8'h00);
            [21'h0F2:21'h0F6], 21'h0F8:             m = map_ent(2'd1, "o", 8'h00, 8'h00);
            [21'h0D9:21'h0DC]:                      m = map_ent(2'd1, "U", 8'h00, 8'h00);
            [21'h0F9:21'h0FC]:                      m = map_ent(2'd1, "u", 8'h00, 8'h00);
            21'h0DD:                                m = map_ent(2'd1, "Y", 8'h00, 8'h00);
            21'h0FD, 21'h0FF:                       m = map_ent(2'd1, "y", 8'h00, 8'h00);
            21'h0DE:                                m = map_ent(2'd2, "T", "h", 8'h00);
            21'h0FE:                                m = map_ent(2'd2, "t", "h", 8'h00);
            21'h0DF:                                m = map_ent(2'd2, "s", "s", 8'h00);
            21'h141:                                m = map_ent(2'd1, "L", 8'h00, 8'h00);
            21'h142:                                m = map_ent(2'd1, "l", 8'h00, 8'h00);
            21'h152:                                m = map_ent(2'd2, "O", "E", 8'h00);
            21'h153:                                m = map_ent(2'd2, "o", "e", 8'h00);
            21'h160:                                m = map_ent(2'd1, "S", 8'h00, 8'h00);
            21'h161:                                m = map_ent(2'd1, "s", 8'h00, 8'h00);
            21'h17D:                                m = map_ent(2'd1, "Z", 8'h00, 8'h00);
            21'h17E:                                m = map_ent(2'd1, "z", 8'h00, 8'h00);
            21'h2018, 21'h2019:                     m = map_ent(2'd1, "'", 8'h00, 8'h00);
            21'h201C, 21'h201D:                     m = map_ent(2'd1, "-", 8'h00, 8'h00);
            21'h2013, 21'h0B7, 21'h2022:            m = map_ent(2'd1, "-", 8'h00, 8'h00);
            21'h2014:                               m = map_ent(2'd2, "-", "-", 8'h00);
            21'h2026:                               m = map_ent(2'd3, ".", ".", ".");
            21'h0A9:                                m = map_ent(2'd3, "(", "c", ")");
            21'h0AE:                                m = map_ent(2'd3, "(", "R", ")");
            21'h2122:                               m = map_ent(2'd2, "T", "M", 8'h00);
            21'h0D7:                                m = map_ent(2'd1, "x", 8'h00, 8'h00);
            21'h266A, 21'h266B:                     m = map_ent(2'd1, "~", 8'h00, 8'h00);
            default:                                m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'b000, nib};
        end else begin
            c = 7'h37 + {3'b000, nib};
        end
        return c;
    endfunction

endpackage

>>> rtl/utf8a_front.sv
// front end: accepts bytes, assembles codepoints and queues them for expansion
module utf8a_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // text_last
    input  logic              q_full,
    output logic              q_push,
    output utf8a_pkg::job_t   q_job
);
    import utf8a_pkg::*;

    logic [CP_W-1:0] accum_reg, accum_next;
    logic [1:0]      pend_reg, pend_next;
    logic            accept;
    logic            done;
    logic [CP_W-1:0] cp;

    assign s_tready = !q_full;
    assign accept = s_tvalid && !q_full;

    always_comb begin
        accum_next = accum_reg;
        pend_next = pend_reg;
        done = 1'b0;
        cp = '0;
        if (accept) begin
            if (pend_reg == 2'd0) begin
                if (!s_tdata[7]) begin
                    cp = {13'b0, s_tdata};
                    done = 1'b1;
                end else if (s_tdata[7:5] == 3'b110) begin
                    accum_next = {16'b0, s_tdata[4:0]};
                    pend_next = 2'd1;
                end else if (s_tdata[7:4] == 4'b1110) begin
                    accum_next = {17'b0, s_tdata[3:0]};
                    pend_next = 2'd2;
                end else if (s_tdata[7:3] == 5'b11110) begin
                    accum_next = {18'b0, s_tdata[2:0]};
                    pend_next = 2'd3;
                end else begin
                    cp = REPLACEMENT_CP;
                    done = 1'b1;
                end
            end else begin
                // continuation bytes are not checked, only their payload is kept
                accum_next = {accum_reg[CP_W-7:0], s_tdata[5:0]};
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    cp = accum_next;
                    done = 1'b1;
                end
            end
            // truncated text: flush the partial value as it stands
            if (!done && s_tlast) begin
                cp = accum_next;
            end
            if (s_tlast) begin
                accum_next = '0;
                pend_next = 2'd0;
            end
        end
    end

    // control codes vanish unless they carry the end of text
    assign q_push = accept && (done || s_tlast) && (s_tlast || cp >= FIRST_PRINTABLE);
    assign q_job.cp = cp;
    assign q_job.last = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
            pend_reg <= 2'd0;
        end else begin
            accum_reg <= accum_next;
            pend_reg <= pend_next;
        end
    end

endmodule

>>> rtl/utf8a_fifo.sv
// short queue of codepoint jobs between front and back end
module utf8a_fifo #(
    parameter int unsigned DEPTH = utf8a_pkg::FIFO_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  utf8a_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output utf8a_pkg::job_t   head_job
);
    import utf8a_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job = mem[rptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/utf8a_back.sv
// back end: expands the queued codepoint into characters, one per cycle while m_tready is high
module utf8a_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  utf8a_pkg::job_t   head_job,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [6:0] out_char, [7] run_last
    output logic              m_tuser,   // char_valid
    output logic              m_tlast    // text_end
);
    import utf8a_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        vld_reg, vld_next;
    logic [6:0]  char_reg;
    logic        cvalid_reg, run_reg, end_reg;

    kind_t       kind;
    map_t        ment;
    logic [2:0]  digits;
    logic [2:0]  n_chars;
    logic [2:0]  nib_sel;
    logic [23:0] cp_wide;
    logic [3:0]  nib;
    logic [6:0]  ch;
    logic        final_char;
    logic        load;

    always_comb begin
        ment = map_lookup(head_job.cp);
        if (head_job.cp < FIRST_PRINTABLE) begin
            kind = KIND_MARK;
        end else if (head_job.cp < FIRST_NON_ASCII) begin
            kind = KIND_ASCII;
        end else if (ment.hit) begin
            kind = KIND_MAP;
        end else begin
            kind = KIND_HEX;
        end
    end

    always_comb begin
        if (head_job.cp <= HEX4_MAX) begin
            digits = 3'd4;
        end else if (head_job.cp <= HEX5_MAX) begin
            digits = 3'd5;
        end else begin
            digits = 3'd6;
        end
        cp_wide = {3'b000, head_job.cp};
        nib_sel = digits - idx_reg;
        nib = cp_wide[{nib_sel, 2'b00} +: 4];
    end

    always_comb begin
        n_chars = 3'd1;
        ch = '0;
        unique case (kind)
            KIND_MARK: begin
                n_chars = 3'd1;
                ch = '0;
            end
            KIND_ASCII: begin
                n_chars = 3'd1;
                ch = head_job.cp[6:0];
            end
            KIND_MAP: begin
                n_chars = {1'b0, ment.len};
                ch = (idx_reg == 3'd0) ? ment.c0 : (idx_reg == 3'd1) ? ment.c1 : ment.c2;
            end
            KIND_HEX: begin
                // six-digit codepoints have no closing bracket
                n_chars = (digits == 3'd6) ? 3'd7 : digits + 3'd2;
                if (idx_reg == 3'd0) begin
                    ch = CHAR_OPEN;
                end else if (idx_reg <= digits) begin
                    ch = hex_char(nib);
                end else begin
                    ch = CHAR_CLOSE;
                end
            end
            default: begin
                n_chars = 3'd1;
                ch = '0;
            end
        endcase
        final_char = (idx_reg == n_chars - 3'd1);
    end

    assign load = head_valid && (!vld_reg || m_tready);
    assign pop = load && final_char;

    always_comb begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
            idx_next = final_char ? 3'd0 : idx_reg + 3'd1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= ch;
            cvalid_reg <= (kind != KIND_MARK);
            run_reg <= final_char;
            end_reg <= final_char && head_job.last;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata = {run_reg, char_reg};
    assign m_tuser = cvalid_reg;
    assign m_tlast = end_reg;

endmodule

>>> rtl/utf8_ascii_transliterator.sv
// utf-8 to ascii transliterator top level
// path: a byte's first character is held in the job queue, then the output register
// throughput: one byte per cycle while each gives at most one character and m_tready
// is high; a codepoint of n characters holds the output register until all are out,
// the job queue between front and back end absorbs the difference
// reset: synchronous active-low aresetn clears decoder state, queue and output valid
module utf8_ascii_transliterator #(
    parameter int unsigned FIFO_DEPTH = utf8a_pkg::FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // text_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] run_last
    output logic       m_tuser,   // char_valid
    output logic       m_tlast    // text_end
);
    import utf8a_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    job_t q_in, q_head;

    utf8a_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_in)
    );

    utf8a_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    utf8a_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_job   (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/utf8a_checker.sv
// port-level checks on the transliterator output stream, bound to the top level
module utf8a_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // stalled transaction keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // end of text always closes the run of its byte
    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7])
        else $error("text end without run end");

    // a bare end marker carries no character and closes the text
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'h80))
        else $error("malformed end marker");

    a_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[6:0] >= 7'h20))
        else $error("control code on output");

endmodule

bind utf8_ascii_transliterator utf8a_checker u_chk (.*);

>>> verif/utf8_ascii_transliterator_tb.sv
// self-checking testbench of the utf-8 to ascii transliterator with its own predictor
module utf8_ascii_transliterator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] ch;
        logic       cvalid;
        logic       run_last;
        logic       text_end;
    } ascii_out_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } byte_item_t;

    // one directed byte; txt holds the characters expected from it when typed is set
    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        typed;
        logic [55:0] txt;
    } probe_row_t;

    localparam int N_PROBE = 25;
    localparam int N_RANDOM = 345;
    localparam int CALM_TAIL = 40;

    localparam probe_row_t PROBES [N_PROBE] = '{
        '{8'h41, 1'b0, 1'b1, "A"},
        '{8'h00, 1'b0, 1'b1, 56'h0},
        '{8'h1F, 1'b0, 1'b1, 56'h0},
        '{8'h20, 1'b0, 1'b1, " "},
        '{8'h7F, 1'b0, 1'b1, 56'h7F},
        '{8'h80, 1'b0, 1'b1, "<FFFD>"},
        '{8'hF8, 1'b0, 1'b1, "<FFFD>"},
        '{8'hFF, 1'b0, 1'b1, "<FFFD>"},
        '{8'hC2, 1'b0, 1'b1, 56'h0},
        '{8'hA9, 1'b0, 1'b0, 56'h0},
        '{8'hE2, 1'b0, 1'b1, 56'h0},
        '{8'h80, 1'b0, 1'b1, 56'h0},
        '{8'hA6, 1'b0, 1'b0, 56'h0},
        '{8'hF4, 1'b0, 1'b1, 56'h0},
        '{8'h8F, 1'b0, 1'b1, 56'h0},
        '{8'hBF, 1'b0, 1'b1, 56'h0},
        '{8'hBF, 1'b0, 1'b0, 56'h0},
        '{8'hF0, 1'b0, 1'b1, 56'h0},
        '{8'h9F, 1'b0, 1'b1, 56'h0},
        '{8'h98, 1'b0, 1'b1, 56'h0},
        '{8'h80, 1'b0, 1'b0, 56'h0},
        '{8'hE0, 1'b0, 1'b1, 56'h0},
        '{8'hC0, 1'b1, 1'b1, 56'h0},
        '{8'hC5, 1'b1, 1'b1, 56'h0},
        '{8'h7E, 1'b1, 1'b1, "~"}
    };

    // codepoints worth hitting on purpose: folded letters and symbols, hex width edges
    localparam logic [20:0] NOTABLE_CPS [30] = '{
        21'h0C0, 21'h0C5, 21'h0E9, 21'h0C6, 21'h0E6, 21'h0D8, 21'h0DF, 21'h0FF,
        21'h0DE, 21'h0FE, 21'h141, 21'h153, 21'h17E, 21'h2018, 21'h201D, 21'h2014,
        21'h2026, 21'h0B7, 21'h0A9, 21'h0AE, 21'h2122, 21'h0D7, 21'h266B, 21'h0A0,
        21'h100, 21'h7FF, 21'hFFFF, 21'h10000, 21'h100000, 21'h1FFFFF
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b1;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    ascii_out_t  char_q[$];
    ascii_out_t  oldest;
    byte_item_t  stim[$];
    logic [20:0] cp_acc = '0;
    logic [1:0]  cont_left = '0;
    int          n_errors = 0;
    int          n_results = 0;
    int          n_bytes = 0;
    int          n_texts = 0;
    int          send_pct = 0;
    int          recv_pct = 0;
    bit          calm = 1'b0;

    utf8_ascii_transliterator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic string latin_fold(input logic [20:0] cp);
        string s;
        s = "";
        case (cp) inside
            [21'h0C0:21'h0C5]:                   s = "A";
            [21'h0E0:21'h0E5]:                   s = "a";
            21'h0C6:                             s = "AE";
            21'h0E6:                             s = "ae";
            21'h0C7:                             s = "C";
            21'h0E7:                             s = "c";
            [21'h0C8:21'h0CB]:                   s = "E";
            [21'h0E8:21'h0EB]:                   s = "e";
            [21'h0CC:21'h0CF]:                   s = "I";
            [21'h0EC:21'h0EF]:                   s = "i";
            21'h0D0:                             s = "D";
            21'h0F0:                             s = "d";
            21'h0D1:                             s = "N";
            21'h0F1:                             s = "n";
            [21'h0D2:21'h0D6], 21'h0D8:          s = "O";
            [21'h0F2:21'h0F6], 21'h0F8:          s = "o";
            [21'h0D9:21'h0DC]:                   s = "U";
            [21'h0F9:21'h0FC]:                   s = "u";
            21'h0DD:                             s = "Y";
            21'h0FD, 21'h0FF:                    s = "y";
            21'h0DE:                             s = "Th";
            21'h0FE:                             s = "th";
            21'h0DF:                             s = "ss";
            21'h141:                             s = "L";
            21'h142:                             s = "l";
            21'h152:                             s = "OE";
            21'h153:                             s = "oe";
            21'h160:                             s = "S";
            21'h161:                             s = "s";
            21'h17D:                             s = "Z";
            21'h17E:                             s = "z";
            21'h2018, 21'h2019:                  s = "'";
            21'h201C, 21'h201D, 21'h2013,
            21'h0B7, 21'h2022:                   s = "-";
            21'h2014:                            s = "--";
            21'h2026:                            s = "...";
            21'h0A9:                             s = "(c)";
            21'h0AE:                             s = "(R)";
            21'h2122:                            s = "TM";
            21'h0D7:                             s = "x";
            21'h266A, 21'h266B:                  s = "~";
            default:                             s = "";
        endcase
        return s;
    endfunction

    function automatic string cp_to_ascii(input logic [20:0] cp);
        string hexd;
        string s;
        int    nd;
        int    d;
        int    nib;
        hexd = "0123456789ABCDEF";
        if (cp < 21'h80) begin
            if (cp >= 21'h20) begin
                return $sformatf("%c", cp[7:0]);
            end
            return "";
        end
        s = latin_fold(cp);
        if (s.len() != 0) begin
            return s;
        end
        nd = (cp <= 21'hFFFF) ? 4 : (cp <= 21'hFFFFF) ? 5 : 6;
        s = "<";
        for (d = nd - 1; d >= 0; d--) begin
            nib = int'((cp >> (4 * d)) & 21'hF);
            s = {s, hexd.substr(nib, nib)};
        end
        // six-digit codepoints lose the closing bracket
        if (nd < 6) begin
            s = {s, ">"};
        end
        return s;
    endfunction

    // decoder state update for one accepted byte; returns the characters it releases
    function automatic string advance_decoder(input logic [7:0] b, input logic last);
        logic [20:0] cp;
        logic        ready;
        string       txt;
        cp = '0;
        ready = 1'b0;
        txt = "";
        if (cont_left == 2'd0) begin
            if (!b[7]) begin
                cp = {13'd0, b};
                ready = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                cp_acc = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                cp_acc = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                cp_acc = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end else begin
                cp = utf8a_pkg::REPLACEMENT_CP;
                ready = 1'b1;
            end
        end else begin
            // top bits of a continuation byte are ignored
            cp_acc = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp = cp_acc;
                ready = 1'b1;
            end
        end
        // text cut short: convert the partial value unshifted
        if (!ready && last) begin
            cp = cp_acc;
            ready = 1'b1;
        end
        if (ready) begin
            txt = cp_to_ascii(cp);
        end
        if (last) begin
            cp_acc = '0;
            cont_left = '0;
        end
        return txt;
    endfunction

    function automatic void queue_chars(input string txt, input logic last);
        ascii_out_t r;
        logic [7:0] c;
        int         k;
        if (txt.len() == 0) begin
            if (last) begin
                r = '{7'd0, 1'b0, 1'b1, 1'b1};
                char_q.push_back(r);
            end
            return;
        end
        for (k = 0; k < txt.len(); k++) begin
            c = txt[k];
            r.ch = c[6:0];
            r.cvalid = 1'b1;
            r.run_last = (k == txt.len() - 1);
            r.text_end = r.run_last & last;
            char_q.push_back(r);
        end
    endfunction

    function automatic string unpack_text(input logic [55:0] v);
        string      s;
        logic [7:0] c;
        int         k;
        s = "";
        for (k = 6; k >= 0; k--) begin
            c = v[8 * k +: 8];
            if (c != 8'h00) begin
                s = $sformatf("%s%c", s, c);
            end
        end
        return s;
    endfunction

    function automatic int pick_idle_pct();
        int p;
        case ($urandom_range(0, 3))
            0: p = 0;
            1: p = 4;
            2: p = 15;
            default: p = 40;
        endcase
        return p;
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic last);
        byte_item_t it;
        it.b = b;
        it.last = last;
        stim.push_back(it);
    endfunction

    // encodes cp in len bytes but stops after nbytes; wild scrambles continuation top bits
    function automatic void add_encoded(input logic [20:0] cp, input int len,
                                        input int nbytes, input bit wild);
        logic [7:0] lead;
        logic [1:0] top;
        int         i;
        int         sh;
        case (len)
            2: lead = {3'b110, cp[10:6]};
            3: lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        add_byte(lead, 1'b0);
        for (i = 1; i < nbytes; i++) begin
            sh = 6 * (len - 1 - i);
            top = wild ? 2'($urandom_range(0, 3)) : 2'b10;
            add_byte({top, cp[sh +: 6]}, 1'b0);
        end
    endfunction

    function automatic int min_len(input logic [20:0] cp);
        return (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
    endfunction

    function automatic void add_piece();
        logic [20:0] cp;
        int          len;
        int          sel;
        sel = $urandom_range(0, 19);
        if (sel <= 5) begin
            add_byte(8'($urandom_range(8'h20, 8'h7F)), 1'b0);
        end else if (sel == 6) begin
            add_byte(8'($urandom_range(8'h00, 8'h1F)), 1'b0);
        end else if (sel <= 11 || sel >= 18) begin
            cp = NOTABLE_CPS[$urandom_range(0, 29)];
            len = min_len(cp);
            // now and then an overlong form of the same codepoint
            if (len < 4 && $urandom_range(0, 7) == 0) begin
                len++;
            end
            add_encoded(cp, len, len, 1'b0);
        end else if (sel <= 14) begin
            len = $urandom_range(2, 4);
            cp = 21'($urandom) & ((len == 2) ? 21'h7FF : (len == 3) ? 21'hFFFF : 21'h1FFFFF);
            add_encoded(cp, len, len, 1'b0);
        end else if (sel == 15) begin
            if ($urandom_range(0, 1) == 0) begin
                add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end else begin
                add_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
            end
        end else if (sel == 16) begin
            // text ends part-way through a codepoint
            len = $urandom_range(2, 4);
            cp = 21'($urandom);
            add_encoded(cp, len, $urandom_range(1, len - 1), ($urandom_range(0, 1) == 1));
            stim[stim.size() - 1].last = 1'b1;
            return;
        end else begin
            len = $urandom_range(2, 4);
            cp = 21'($urandom);
            add_encoded(cp, len, len, 1'b1);
        end
        if ($urandom_range(0, 9) == 0) begin
            stim[stim.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 99) < send_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        n_bytes++;
        if (last) begin
            n_texts++;
        end
    endtask

    task automatic drain_chars();
        do @(posedge aclk); while (char_q.size() != 0);
    endtask

    initial begin
        int    i;
        string txt;
        while (stim.size() < N_RANDOM) begin
            add_piece();
        end
        stim[stim.size() - 1].last = 1'b1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_PROBE; i++) begin
            send_byte(PROBES[i].b, PROBES[i].last);
            txt = advance_decoder(PROBES[i].b, PROBES[i].last);
            if (PROBES[i].typed) begin
                txt = unpack_text(PROBES[i].txt);
            end
            queue_chars(txt, PROBES[i].last);
        end

        for (i = 0; i < stim.size(); i++) begin
            if (i % 32 == 0) begin
                send_pct = pick_idle_pct();
            end
            if (i == stim.size() - CALM_TAIL) begin
                calm = 1'b1;
            end
            // sender holds off until the output side has caught up
            if (i == 100 || i == 220) begin
                s_tvalid <= 1'b0;
                drain_chars();
            end
            send_byte(stim[i].b, stim[i].last);
            queue_chars(advance_decoder(stim[i].b, stim[i].last), stim[i].last);
        end
        s_tvalid <= 1'b0;

        drain_chars();
        repeat (16) @(posedge aclk);
        $display("%0d bytes sent in %0d texts, %0d output transactions checked",
                 n_bytes, n_texts, n_results);
        $display("covered ascii, control codes, folded letters, hex escapes, bad leads, %s",
                 "cut-off texts");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // output back-pressure in bursts, switched off for the tail of the run
    initial begin
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 39) == 0) begin
                recv_pct = pick_idle_pct();
            end
            if (aresetn && !calm && $urandom_range(0, 99) < recv_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (char_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, %s %02h tuser %b tlast %b",
                         $time, "actual char", m_tdata[6:0], m_tuser, m_tlast);
                n_errors++;
            end else begin
                oldest = char_q.pop_front();
                if (m_tdata[6:0] !== oldest.ch) begin
                    $display("%0t: out_char expected %02h actual %02h",
                             $time, oldest.ch, m_tdata[6:0]);
                    n_errors++;
                end
                if (m_tuser !== oldest.cvalid) begin
                    $display("%0t: char_valid expected %b actual %b",
                             $time, oldest.cvalid, m_tuser);
                    n_errors++;
                end
                if (m_tdata[7] !== oldest.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, oldest.run_last, m_tdata[7]);
                    n_errors++;
                end
                if (m_tlast !== oldest.text_end) begin
                    $display("%0t: text_end expected %b actual %b",
                             $time, oldest.text_end, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timed out with %0d transactions outstanding", char_q.size());
        $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/utf8a_pkg.sv
rtl/utf8a_front.sv
rtl/utf8a_fifo.sv
rtl/utf8a_back.sv
rtl/utf8_ascii_transliterator.sv
rtl/utf8a_checker.sv
verif/utf8_ascii_transliterator_tb.sv
